// ===== hdl/dominant_segment_masker_defines.svh =====
// Assertion macros used by the dominant segment masker top level.
`ifndef DOMINANT_SEGMENT_MASKER_DEFINES_SVH
`define DOMINANT_SEGMENT_MASKER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DSM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DSM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dsm_pkg.sv =====
// Shared types, constants and the palette table of the dominant segment masker.
package dsm_pkg;

    // Palette size and the fixed widths that follow from it.
    localparam int PALETTE_SIZE = 7;
    localparam int IDX_W        = 3;
    localparam int MASK_W       = 7;

    // One color, channel bytes.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // Clear command broadcast from the ranking control to every cell.
    typedef struct packed {
        logic             clr_all;
        logic             clr_one;
        logic [IDX_W-1:0] idx;
    } t_clr_cmd;

    localparam t_rgb WHITE = '{red: 8'd255, green: 8'd255, blue: 8'd255};
    localparam t_rgb BLACK = '{red: 8'd0, green: 8'd0, blue: 8'd0};

    // Palette color of a bin; indexes past the palette read as black.
    function automatic t_rgb palette_color(input logic [IDX_W-1:0] idx);
        t_rgb c;
        case (idx)
            3'd0:    c = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
            3'd1:    c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
            3'd2:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
            3'd3:    c = '{red: 8'd100, green: 8'd100, blue: 8'd255};
            3'd4:    c = '{red: 8'd255, green: 8'd0,   blue: 8'd255};
            3'd5:    c = '{red: 8'd255, green: 8'd255, blue: 8'd0};
            default: c = BLACK;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/dsm_cell.sv =====
// One histogram bin: counts matching pixels and forwards the running maximum.
module dsm_cell #(
    parameter int                  COUNT_BITS = 21,
    parameter logic [dsm_pkg::IDX_W-1:0] IDX  = '0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cnt_en,
    input  dsm_pkg::t_rgb             i_pixel,
    input  dsm_pkg::t_clr_cmd         i_cmd,
    input  logic [COUNT_BITS-1:0]     i_best_val,
    input  logic [dsm_pkg::IDX_W-1:0] i_best_idx,
    output logic [COUNT_BITS-1:0]     o_best_val,
    output logic [dsm_pkg::IDX_W-1:0] o_best_idx
);

    localparam dsm_pkg::t_rgb MY_COLOR = dsm_pkg::palette_color(IDX);

    logic [COUNT_BITS-1:0]     r_count;
    logic [COUNT_BITS-1:0]     n_count;
    logic [COUNT_BITS-1:0]     r_best_val;
    logic [dsm_pkg::IDX_W-1:0] r_best_idx;

    // Bin count: cleared on command, otherwise a saturating increment on a match.
    always_comb begin
        n_count = r_count;
        if (i_cmd.clr_all || (i_cmd.clr_one && (i_cmd.idx == IDX))) begin
            n_count = '0;
        end else if (i_cnt_en && (i_pixel == MY_COLOR) && (r_count != '1)) begin
            n_count = r_count + COUNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Running maximum; a strict compare keeps ties on the lower index upstream.
    always_ff @(posedge i_clk) begin
        if (r_count > i_best_val) begin
            r_best_val <= r_count;
            r_best_idx <= IDX;
        end else begin
            r_best_val <= i_best_val;
            r_best_idx <= i_best_idx;
        end
    end

    assign o_best_val = r_best_val;
    assign o_best_idx = r_best_idx;

endmodule

// ===== hdl/dsm_rank_ctrl.sv =====
// Ranking sequencer: picks the dominant bins one at a time from the cell chain.
module dsm_rank_ctrl #(
    parameter int BIN_TOTAL = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [2:0]                 i_dom_count,
    input  logic                       i_top_valid,
    input  logic [dsm_pkg::IDX_W-1:0]  i_top_idx,
    output logic                       o_busy,
    output dsm_pkg::t_clr_cmd          o_cmd,
    output logic [dsm_pkg::MASK_W-1:0] o_masked
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RANK = 2'b10
    } t_state;

    t_state                     r_state, n_state;
    logic [2:0]                 r_wait, n_wait;
    logic [2:0]                 r_left, n_left;
    logic [dsm_pkg::MASK_W-1:0] r_chosen, n_chosen;
    logic [dsm_pkg::MASK_W-1:0] r_masked, n_masked;

    // Each pick waits for the chain to settle, then takes the tail maximum.
    always_comb begin
        n_state  = r_state;
        n_wait   = r_wait;
        n_left   = r_left;
        n_chosen = r_chosen;
        n_masked = r_masked;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state  = S_RANK;
                    n_wait   = 3'(BIN_TOTAL);
                    n_left   = i_dom_count;
                    n_chosen = '0;
                end
            end
            S_RANK: begin
                if (r_wait != 3'd0) begin
                    n_wait = r_wait - 3'd1;
                end else if ((r_left == 3'd0) || !i_top_valid) begin
                    n_masked      = r_chosen;
                    o_cmd.clr_all = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    n_chosen      = r_chosen | (dsm_pkg::MASK_W'(1) << i_top_idx);
                    o_cmd.clr_one = 1'b1;
                    o_cmd.idx     = i_top_idx;
                    n_left        = r_left - 3'd1;
                    n_wait        = 3'(BIN_TOTAL);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wait   <= '0;
            r_left   <= '0;
            r_masked <= '0;
        end else begin
            r_state  <= n_state;
            r_wait   <= n_wait;
            r_left   <= n_left;
            r_masked <= n_masked;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chosen <= n_chosen;
    end

    assign o_busy   = (r_state == S_RANK);
    assign o_masked = r_masked;

endmodule

// ===== hdl/dominant_segment_masker.sv =====
// Top level of the dominant segment masker: stream ports, bin chain and output register.
//
// Input items arrive on the slave stream. tuser selects the kind: 0 counts the
// pixel in tdata against a seven-color palette, 1 maps the segment label in
// tdata. tlast on a count item marks the last pixel of a frame.
// Map items give one registered result item on the master stream: the
// label's palette color, or white with tuser set when the label is one of
// the dominant bins. Count items give no result. Count and map items are
// taken one per cycle while the block is not ranking and its output register
// can take a result. A last pixel starts ranking: the block then holds tready
// low until ranking ends; each pick waits for the running maximum to ripple
// through the B-cell compare chain, where B is the number of bins. The
// histogram is cleared when ranking ends. A stalled receiver holds the
// result in the output register; a new item is taken only when that register
// is empty or drained in the same cycle. Reset clears the histogram and the
// masked set and sets the dominant count to two. The user writes the count
// register through i_cfg_we only while idle; the block does not enforce this.
module dominant_segment_masker #(
    parameter int NUM_COLORS = 7,
    parameter int COUNT_BITS = 21
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: dominant_count.
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    // Slave stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // pixel_red, pixel_green, pixel_blue, segment_label
    input  logic        i_s_tlast,  // last_pixel
    input  logic        i_s_tuser,  // opcode
    // Master stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,  // out_red, out_green, out_blue
    output logic        o_m_tuser   // was_masked
);

    `include "dominant_segment_masker_defines.svh"

    localparam int BIN_TOTAL = (NUM_COLORS < dsm_pkg::PALETTE_SIZE) ?
                               NUM_COLORS : dsm_pkg::PALETTE_SIZE;

    logic [2:0]                 r_dom_count;
    logic                       w_busy;
    logic                       w_accept;
    logic                       w_cnt_en;
    logic                       w_start;
    logic                       w_map;
    dsm_pkg::t_rgb              w_pixel;
    logic [dsm_pkg::IDX_W-1:0]  w_label;
    dsm_pkg::t_clr_cmd          w_cmd;
    logic [dsm_pkg::MASK_W-1:0] w_masked;
    logic [dsm_pkg::MASK_W:0]   w_masked_ext;
    logic                       w_lbl_masked;
    dsm_pkg::t_rgb              w_color;
    logic                       r_out_valid;
    dsm_pkg::t_rgb              r_out_color;
    logic                       r_out_masked;

    logic [COUNT_BITS-1:0]     w_best_val [0:BIN_TOTAL];
    logic [dsm_pkg::IDX_W-1:0] w_best_idx [0:BIN_TOTAL];

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dom_count <= 3'd2;
        end else if (i_cfg_we) begin
            r_dom_count <= i_cfg_wdata;
        end
    end

    // Input handshake and item decode.
    assign o_s_tready = !w_busy && (!r_out_valid || i_m_tready);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_cnt_en   = w_accept && !i_s_tuser;
    assign w_start    = w_cnt_en && i_s_tlast;
    assign w_map      = w_accept && i_s_tuser;
    assign w_pixel.red   = i_s_tdata[7:0];
    assign w_pixel.green = i_s_tdata[15:8];
    assign w_pixel.blue  = i_s_tdata[23:16];
    assign w_label       = i_s_tdata[26:24];

    // Chain of bin cells; the head starts from an empty maximum.
    assign w_best_val[0] = '0;
    assign w_best_idx[0] = '0;

    for (genvar g = 0; g < BIN_TOTAL; g++) begin : g_cell
        dsm_cell #(
            .COUNT_BITS (COUNT_BITS),
            .IDX        (dsm_pkg::IDX_W'(g))
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cnt_en   (w_cnt_en),
            .i_pixel    (w_pixel),
            .i_cmd      (w_cmd),
            .i_best_val (w_best_val[g]),
            .i_best_idx (w_best_idx[g]),
            .o_best_val (w_best_val[g+1]),
            .o_best_idx (w_best_idx[g+1])
        );
    end

    // Ranking sequencer.
    dsm_rank_ctrl #(
        .BIN_TOTAL (BIN_TOTAL)
    ) u_rank_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_dom_count (r_dom_count),
        .i_top_valid (w_best_val[BIN_TOTAL] != '0),
        .i_top_idx   (w_best_idx[BIN_TOTAL]),
        .o_busy      (w_busy),
        .o_cmd       (w_cmd),
        .o_masked    (w_masked)
    );

    // Label lookup; the out-of-range label reads an always-clear bit and black.
    assign w_masked_ext = {1'b0, w_masked};
    assign w_lbl_masked = w_masked_ext[w_label];
    assign w_color      = w_lbl_masked ? dsm_pkg::WHITE : dsm_pkg::palette_color(w_label);

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_map) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_map) begin
            r_out_color  <= w_color;
            r_out_masked <= w_lbl_masked;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_color.blue, r_out_color.green, r_out_color.red};
    assign o_m_tuser  = r_out_masked;

    // A masked result is always white.
    `DSM_ASSERT_NOW(a_masked_white, o_m_tvalid && o_m_tuser, o_m_tdata == 24'hFFFFFF,
        "masked result is not white")

    // A last pixel stops intake while ranking runs.
    `DSM_ASSERT_NEXT(a_rank_stalls, w_start, !o_s_tready,
        "item taken during ranking")

    // Only existing bins can be masked.
    `DSM_ASSERT_NOW(a_mask_range, 1'b1,
        (w_masked >> BIN_TOTAL) == dsm_pkg::MASK_W'(0),
        "masked bit beyond the bin count")

endmodule

// ===== sim/dsm_test_pkg.sv =====
// Opcode codes and the palette lookup shared by the masker testbench files.
package dsm_test_pkg;

    // Kind of an input item, carried on tuser of the slave stream.
    typedef enum logic {
        OP_COUNT = 1'b0,
        OP_MAP   = 1'b1
    } t_opcode;

    // Number of palette bins, and the cycles to let pass after the last result
    // so that a ranking pass started by a last pixel has surely finished.
    localparam int PALETTE_BINS        = 7;
    localparam int RANK_SETTLE_CYCLES  = 80;

    // Palette color of a bin; anything past the palette reads as black.
    function automatic dsm_pkg::t_rgb palette_rgb(input int idx);
        dsm_pkg::t_rgb c;
        case (idx)
            0:       c = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
            1:       c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
            2:       c = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
            3:       c = '{red: 8'd100, green: 8'd100, blue: 8'd255};
            4:       c = '{red: 8'd255, green: 8'd0,   blue: 8'd255};
            5:       c = '{red: 8'd255, green: 8'd255, blue: 8'd0};
            default: c = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
        endcase
        return c;
    endfunction

endpackage

// ===== sim/masked_color_checker.sv =====
// Checker that tracks the histogram and masked set and compares every mapped color.
module masked_color_checker #(
    parameter int NUM_COLORS = 7,
    parameter int COUNT_BITS = 21
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,   // pixel_red, pixel_green, pixel_blue, segment_label
    input  logic        i_s_tlast,   // last_pixel
    input  logic        i_s_tuser,   // opcode
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // out_red, out_green, out_blue
    input  logic        i_m_tuser,   // was_masked
    output int          o_mismatch_count,
    output int          o_pending_count
);

    localparam int BIN_TOTAL = (NUM_COLORS < dsm_test_pkg::PALETTE_BINS) ?
                               NUM_COLORS : dsm_test_pkg::PALETTE_BINS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // One mapped color as the block should return it.
    typedef struct packed {
        dsm_pkg::t_rgb color;
        logic          masked;
    } t_map_result;

    logic [COUNT_BITS-1:0]      bin_count [dsm_test_pkg::PALETTE_BINS];
    logic [dsm_pkg::MASK_W-1:0] masked_bins;
    logic [2:0]                 dominant_count;
    t_map_result                expected_colors [$];
    int                         mismatch_total;

    // Picks the most populated bins one after another, then clears the histogram.
    function automatic void rank_frame();
        logic [dsm_pkg::MASK_W-1:0] chosen;
        logic [COUNT_BITS-1:0]      best;
        int                         best_bin;
        int                         pick;
        int                         b;
        chosen = '0;
        for (pick = 0; pick < dominant_count; pick++) begin
            best     = '0;
            best_bin = -1;
            // Strictly greater keeps ties on the lowest index and skips empty bins.
            for (b = 0; b < BIN_TOTAL; b++) begin
                if (bin_count[b] > best) begin
                    best     = bin_count[b];
                    best_bin = b;
                end
            end
            if (best_bin >= 0) begin
                chosen[best_bin]    = 1'b1;
                bin_count[best_bin] = '0;
            end
        end
        masked_bins = chosen;
        for (b = 0; b < dsm_test_pkg::PALETTE_BINS; b++) begin
            bin_count[b] = '0;
        end
    endfunction

    // Adds one pixel to the bin whose palette color it matches exactly.
    function automatic void count_pixel(input dsm_pkg::t_rgb pix);
        int b;
        for (b = 0; b < BIN_TOTAL; b++) begin
            if (dsm_test_pkg::palette_rgb(b) == pix && bin_count[b] != COUNT_MAX) begin
                bin_count[b] = bin_count[b] + 1'b1;
            end
        end
    endfunction

    // Color the block returns for a segment label under the current masked set.
    function automatic t_map_result predict_color(input logic [2:0] label);
        t_map_result r;
        if (label >= dsm_test_pkg::PALETTE_BINS) begin
            r = '{color: dsm_pkg::BLACK, masked: 1'b0};
        end else if (masked_bins[label]) begin
            r = '{color: dsm_pkg::WHITE, masked: 1'b1};
        end else begin
            r = '{color: dsm_test_pkg::palette_rgb(label), masked: 1'b0};
        end
        return r;
    endfunction

    // Sampled at the rising edge; all channels are driven by nonblocking updates.
    always @(posedge i_clk) begin
        t_map_result   exp_r;
        dsm_pkg::t_rgb got;
        dsm_pkg::t_rgb pix;
        int            b;
        if (!i_rst_n) begin
            for (b = 0; b < dsm_test_pkg::PALETTE_BINS; b++) begin
                bin_count[b] = '0;
            end
            masked_bins    = '0;
            dominant_count = 3'd2;
            mismatch_total = 0;
            expected_colors.delete();
        end else begin
            // A result leaving now belongs to an item taken earlier.
            if (i_m_tvalid && i_m_tready) begin
                got = '{red: i_m_tdata[7:0], green: i_m_tdata[15:8], blue: i_m_tdata[23:16]};
                if (expected_colors.size() == 0) begin
                    mismatch_total++;
                    $display("%0t: unexpected result, expected none, actual color %h masked %b",
                             $time, got, i_m_tuser);
                end else begin
                    exp_r = expected_colors.pop_front();
                    if (got.red !== exp_r.color.red) begin
                        mismatch_total++;
                        $display("%0t: out_red mismatch, expected %0d, actual %0d",
                                 $time, exp_r.color.red, got.red);
                    end
                    if (got.green !== exp_r.color.green) begin
                        mismatch_total++;
                        $display("%0t: out_green mismatch, expected %0d, actual %0d",
                                 $time, exp_r.color.green, got.green);
                    end
                    if (got.blue !== exp_r.color.blue) begin
                        mismatch_total++;
                        $display("%0t: out_blue mismatch, expected %0d, actual %0d",
                                 $time, exp_r.color.blue, got.blue);
                    end
                    if (i_m_tuser !== exp_r.masked) begin
                        mismatch_total++;
                        $display("%0t: was_masked mismatch, expected %b, actual %b",
                                 $time, exp_r.masked, i_m_tuser);
                    end
                end
            end

            if (i_cfg_we) begin
                dominant_count = i_cfg_wdata;
            end

            // Accepted input item: count and maybe rank, or queue a mapped color.
            if (i_s_tvalid && i_s_tready) begin
                if (dsm_test_pkg::t_opcode'(i_s_tuser) == dsm_test_pkg::OP_COUNT) begin
                    pix = '{red: i_s_tdata[7:0], green: i_s_tdata[15:8],
                            blue: i_s_tdata[23:16]};
                    count_pixel(pix);
                    if (i_s_tlast) begin
                        rank_frame();
                    end
                end else begin
                    expected_colors.push_back(predict_color(i_s_tdata[26:24]));
                end
            end
        end
        o_mismatch_count <= mismatch_total;
        o_pending_count  <= expected_colors.size();
    end

endmodule

// ===== sim/dominant_segment_masker_test.sv =====
// Testbench top for the dominant segment masker: stimulus, idling and verdict.
module dominant_segment_masker_test;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_wdata = 3'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;

    int mismatch_count;
    int pending_count;
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;

    dominant_segment_masker dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser)
    );

    masked_color_checker checker_inst (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_s_tvalid       (s_tvalid),
        .i_s_tready       (s_tready),
        .i_s_tdata        (s_tdata),
        .i_s_tlast        (s_tlast),
        .i_s_tuser        (s_tuser),
        .i_m_tvalid       (m_tvalid),
        .i_m_tready       (m_tready),
        .i_m_tdata        (m_tdata),
        .i_m_tuser        (m_tuser),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count)
    );

    // Free-running clock, period 10.
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // The receiver stalls at random at the current rate.
    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Hard limit on the run.
    initial begin
        #10000000;
        $display("Verification failed");
        $finish;
    end

    // Offers one item after a random gap and holds it until it is taken.
    task automatic send_item(input dsm_test_pkg::t_opcode op, input logic last,
                             input dsm_pkg::t_rgb pix, input logic [2:0] label);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= last;
        s_tdata  <= {5'b0, label, pix.blue, pix.green, pix.red};
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    // Stops offering, waits until every mapped color has come back, then for a
    // ranking pass to end.
    task automatic drain_results();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0 && guard < 20000) begin
            @(posedge clk);
            guard++;
        end
        repeat (dsm_test_pkg::RANK_SETTLE_CYCLES) @(posedge clk);
    endtask

    // A short frame leaning on one favorite bin, followed by a burst of label lookups.
    task automatic send_frame();
        int            len;
        int            favorite;
        int            bin;
        int            n;
        int            i;
        dsm_pkg::t_rgb pix;
        len      = $urandom_range(12, 1);
        favorite = $urandom_range(dsm_test_pkg::PALETTE_BINS - 1);
        for (i = 0; i < len; i++) begin
            if ($urandom_range(99) < 15) begin
                pix = dsm_pkg::t_rgb'(24'($urandom()));
            end else begin
                bin = $urandom_range(1) ? favorite
                                        : $urandom_range(dsm_test_pkg::PALETTE_BINS - 1);
                pix = dsm_test_pkg::palette_rgb(bin);
            end
            send_item(dsm_test_pkg::OP_COUNT, i == len - 1, pix, 3'($urandom_range(7)));
        end
        n = $urandom_range(8, 1);
        for (i = 0; i < n; i++) begin
            send_item(dsm_test_pkg::OP_MAP, 1'($urandom_range(1)),
                      dsm_pkg::t_rgb'(24'($urandom())), 3'($urandom_range(7)));
        end
    endtask

    initial begin
        int seg;
        int target;
        int lbl;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every label with nothing masked, last flag toggled on lookups.
        send_gap_pct   = 12;
        recv_stall_pct <= 69;
        for (lbl = 0; lbl < 8; lbl++) begin
            send_item(dsm_test_pkg::OP_MAP, lbl[0], dsm_pkg::t_rgb'(24'hFFFFFF), 3'(lbl));
        end
        // Three-way tie among bins 1, 3 and 5; off-palette and white pixels are ignored,
        // and the last pixel itself is counted.
        send_item(dsm_test_pkg::OP_COUNT, 1'b0, dsm_test_pkg::palette_rgb(3), 3'd7);
        send_item(dsm_test_pkg::OP_COUNT, 1'b0, dsm_test_pkg::palette_rgb(5), 3'd0);
        send_item(dsm_test_pkg::OP_COUNT, 1'b0, dsm_test_pkg::palette_rgb(3), 3'd7);
        send_item(dsm_test_pkg::OP_COUNT, 1'b0, dsm_test_pkg::palette_rgb(5), 3'd0);
        send_item(dsm_test_pkg::OP_COUNT, 1'b0, dsm_test_pkg::palette_rgb(1), 3'd7);
        send_item(dsm_test_pkg::OP_COUNT, 1'b0,
                  '{red: 8'd128, green: 8'd128, blue: 8'd128}, 3'd0);
        send_item(dsm_test_pkg::OP_COUNT, 1'b0, dsm_pkg::WHITE, 3'd7);
        send_item(dsm_test_pkg::OP_COUNT, 1'b1, dsm_test_pkg::palette_rgb(1), 3'd0);
        send_item(dsm_test_pkg::OP_MAP, 1'b0, dsm_pkg::BLACK, 3'd1);
        send_item(dsm_test_pkg::OP_MAP, 1'b0, dsm_pkg::BLACK, 3'd3);
        send_item(dsm_test_pkg::OP_MAP, 1'b1, dsm_pkg::BLACK, 3'd5);
        send_item(dsm_test_pkg::OP_MAP, 1'b0, dsm_pkg::BLACK, 3'd6);
        // A one-pixel frame on the black bin, then a frame with no matching pixel.
        send_item(dsm_test_pkg::OP_COUNT, 1'b1, dsm_pkg::BLACK, 3'd0);
        send_item(dsm_test_pkg::OP_MAP, 1'b0, dsm_pkg::BLACK, 3'd6);
        send_item(dsm_test_pkg::OP_COUNT, 1'b1, '{red: 8'd1, green: 8'd2, blue: 8'd3}, 3'd0);
        send_item(dsm_test_pkg::OP_MAP, 1'b0, dsm_pkg::BLACK, 3'd6);

        // Random phases: the idling pattern changes every three, the count every one.
        for (seg = 0; seg < 9; seg++) begin
            drain_results();
            case (seg / 3)
                0: begin
                    send_gap_pct   = 12;
                    recv_stall_pct <= 69;
                end
                1: begin
                    send_gap_pct   = 69;
                    recv_stall_pct <= 12;
                end
                default: begin
                    send_gap_pct   = 0;
                    recv_stall_pct <= 0;
                end
            endcase
            cfg_we <= 1'b1;
            case (seg % 3)
                0:       cfg_wdata <= 3'd7;
                1:       cfg_wdata <= 3'd0;
                default: cfg_wdata <= 3'($urandom_range(6, 1));
            endcase
            @(posedge clk);
            cfg_we <= 1'b0;
            target = items_sent + 200;
            while (items_sent < target) begin
                if ($urandom_range(99) < 80) begin
                    send_frame();
                end else begin
                    send_item(dsm_test_pkg::t_opcode'($urandom_range(1)),
                              1'($urandom_range(1)),
                              dsm_pkg::t_rgb'(24'($urandom())), 3'($urandom_range(7)));
                end
            end
        end

        drain_results();
        if (pending_count != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_count);
        end
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
